// File: hw/rtl/avs_pkg.sv
// Package for the aging victim select unit.
// Shared widths, defaults, op codes and the command beat passed front to back.
// No dependencies.
`default_nettype none

package avs_pkg;

    localparam int MAX_FRAMES_DEFAULT = 64;
    localparam int AGE_BITS_DEFAULT   = 32;

    localparam int OP_W      = 2;
    localparam int FRAME_W   = 6;
    localparam int AGE_OUT_W = 32;
    localparam int CFG_W     = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_REFERENCE = 2'd0;
    localparam logic [OP_W-1:0] OP_INSTALL   = 2'd1;
    localparam logic [OP_W-1:0] OP_VICTIM    = 2'd2;

    typedef enum logic [1:0] {
        CMD_REFERENCE = 2'd0,
        CMD_INSTALL   = 2'd1,
        CMD_VICTIM    = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [FRAME_W-1:0] frame;
    } cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/aging_victim_select_unit.sv
// Aging victim select unit, top level. The back end applies a reference or install
// in its idle state. Victim request: one pass over the age RAM (one frame per cycle);
// the back end takes no new command until the result is registered. Front queue takes
// beats during a scan while it has room.
// Reset (synchronous, active low) clears marks, hand, queue and result; ages
// need no clearing pass. Depends on avs_pkg, avs_front, avs_back, avs_ram.
`default_nettype none

module aging_victim_select_unit #(
    parameter int MAX_FRAMES = avs_pkg::MAX_FRAMES_DEFAULT,
    parameter int AGE_BITS   = avs_pkg::AGE_BITS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [avs_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [avs_pkg::OP_W-1:0]      s_op,
    input  wire logic [avs_pkg::FRAME_W-1:0]   s_frame_index,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [avs_pkg::FRAME_W-1:0]        m_victim_frame,
    output logic [avs_pkg::AGE_OUT_W-1:0]      m_victim_age
);
    import avs_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    avs_front #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_frame_index (s_frame_index),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    avs_back #(
        .MAX_FRAMES (MAX_FRAMES),
        .AGE_BITS   (AGE_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_victim_frame (m_victim_frame),
        .m_victim_age   (m_victim_age)
    );

endmodule

`default_nettype wire

// File: hw/rtl/avs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module avs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/avs_front.sv
// Front end: accepts input beats, decodes the op, drops ignored ones and
// queues commands for the back end. Depends on avs_pkg.
`default_nettype none

module avs_front #(
    parameter int MAX_FRAMES = avs_pkg::MAX_FRAMES_DEFAULT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [avs_pkg::OP_W-1:0]    s_op,
    input  wire logic [avs_pkg::FRAME_W-1:0] s_frame_index,
    output logic                             cmd_valid,
    input  wire logic                        cmd_ready,
    output avs_pkg::cmd_t                    cmd
);
    import avs_pkg::*;

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            q_reg [QUEUE_DEPTH];
    logic [QW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   count_reg, count_next;

    logic            keep;
    logic            idx_ok;
    cmd_t            dec_cmd;
    logic            push;
    logic            pop;

    assign idx_ok = (32'(s_frame_index) < 32'(MAX_FRAMES));

    always_comb begin
        keep          = 1'b0;
        dec_cmd.kind  = CMD_REFERENCE;
        dec_cmd.frame = s_frame_index;
        unique case (s_op)
            OP_REFERENCE: begin
                keep         = idx_ok;
                dec_cmd.kind = CMD_REFERENCE;
            end
            OP_INSTALL: begin
                keep         = idx_ok;
                dec_cmd.kind = CMD_INSTALL;
            end
            OP_VICTIM: begin
                keep         = 1'b1;
                dec_cmd.kind = CMD_VICTIM;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready   = (count_reg != NW'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    assign push = s_valid && s_ready && keep;
    assign pop  = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NW'(QUEUE_DEPTH))
        else $error("command queue overfilled");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> count_reg < NW'(QUEUE_DEPTH))
        else $error("command pushed into full queue");

    a_pop_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("command popped from empty queue");

endmodule

`default_nettype wire

// File: hw/rtl/avs_back.sv
// Back end: applies reference/install commands, runs the aging + victim scan
// pass over the age RAM, and holds the result register. Depends on avs_pkg, avs_ram.
`default_nettype none

module avs_back #(
    parameter int MAX_FRAMES = avs_pkg::MAX_FRAMES_DEFAULT,
    parameter int AGE_BITS   = avs_pkg::AGE_BITS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [avs_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire avs_pkg::cmd_t                 cmd,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [avs_pkg::FRAME_W-1:0]        m_victim_frame,
    output logic [avs_pkg::AGE_OUT_W-1:0]      m_victim_age
);
    import avs_pkg::*;

    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       cfg_reg;
    logic [MAX_FRAMES-1:0]  ref_reg, ref_next;
    logic [MAX_FRAMES-1:0]  occ_reg, occ_next;
    logic [FW-1:0]          hand_reg, hand_next;
    logic [FW-1:0]          issue_pos_reg, issue_pos_next;
    logic [CW-1:0]          issue_cnt_reg, issue_cnt_next;
    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_first_reg, s1_first_next;
    logic                   s1_occ_reg, s1_occ_next;
    logic                   s1_ref_reg, s1_ref_next;
    logic [FW-1:0]          s1_pos_reg, s1_pos_next;
    logic [FW-1:0]          best_pos_reg, best_pos_next;
    logic [AGE_BITS-1:0]    best_age_reg, best_age_next;
    logic                   found_zero_reg, found_zero_next;
    logic                   m_valid_reg, m_valid_next;
    logic [FRAME_W-1:0]     m_frame_reg, m_frame_next;
    logic [AGE_OUT_W-1:0]   m_age_reg, m_age_next;

    logic [CW-1:0]          n_frames;
    logic [FW-1:0]          start_pos;
    logic [FW-1:0]          cmd_frame;
    logic [AGE_BITS-1:0]    s1_aged;
    logic                   ram_we;
    logic [FW-1:0]          ram_waddr;
    logic [AGE_BITS-1:0]    ram_wdata;
    logic [AGE_BITS-1:0]    ram_rdata;

    avs_ram #(
        .WIDTH (AGE_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_age_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_pos_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (cfg_reg == '0) begin
            n_frames = CW'(1);
        end else if (32'(cfg_reg) > 32'(MAX_FRAMES)) begin
            n_frames = CW'(MAX_FRAMES);
        end else begin
            n_frames = CW'(cfg_reg);
        end
    end

    assign start_pos = (CW'(hand_reg) < n_frames) ? hand_reg : '0;
    assign cmd_frame = FW'(cmd.frame);
    assign cmd_ready = (state_reg == ST_IDLE);

    // Unoccupied frames are never written and count as age zero,
    // so the RAM word is not used for them.
    assign s1_aged = s1_occ_reg ? {s1_ref_reg, ram_rdata[AGE_BITS-1:1]} : '0;

    assign m_valid        = m_valid_reg;
    assign m_victim_frame = m_frame_reg;
    assign m_victim_age   = m_age_reg;

    always_comb begin
        state_next      = state_reg;
        ref_next        = ref_reg;
        occ_next        = occ_reg;
        hand_next       = hand_reg;
        issue_pos_next  = issue_pos_reg;
        issue_cnt_next  = issue_cnt_reg;
        s1_valid_next   = 1'b0;
        s1_first_next   = s1_first_reg;
        s1_occ_next     = s1_occ_reg;
        s1_ref_next     = s1_ref_reg;
        s1_pos_next     = s1_pos_reg;
        best_pos_next   = best_pos_reg;
        best_age_next   = best_age_reg;
        found_zero_next = found_zero_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_frame_next    = m_frame_reg;
        m_age_next      = m_age_reg;
        ram_we          = 1'b0;
        ram_waddr       = s1_pos_reg;
        ram_wdata       = s1_aged;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.kind)
                        CMD_REFERENCE: begin
                            ref_next[cmd_frame] = 1'b1;
                        end
                        CMD_INSTALL: begin
                            ref_next[cmd_frame] = 1'b1;
                            occ_next[cmd_frame] = 1'b1;
                            ram_we              = 1'b1;
                            ram_waddr           = cmd_frame;
                            ram_wdata           = '0;
                        end
                        CMD_VICTIM: begin
                            issue_pos_next  = start_pos;
                            issue_cnt_next  = '0;
                            found_zero_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (issue_cnt_reg < n_frames) begin
                    s1_valid_next  = 1'b1;
                    s1_first_next  = (issue_cnt_reg == '0);
                    s1_occ_next    = occ_reg[issue_pos_reg];
                    s1_ref_next    = ref_reg[issue_pos_reg];
                    s1_pos_next    = issue_pos_reg;
                    issue_cnt_next = issue_cnt_reg + CW'(1);
                    issue_pos_next = (CW'(issue_pos_reg) + CW'(1) >= n_frames) ?
                                     '0 : issue_pos_reg + FW'(1);
                end else if (!s1_valid_reg) begin
                    state_next = ST_FINISH;
                end
                if (s1_valid_reg) begin
                    if (s1_occ_reg) begin
                        ram_we              = 1'b1;
                        ref_next[s1_pos_reg] = 1'b0;
                    end
                    if (s1_first_reg) begin
                        best_pos_next   = s1_pos_reg;
                        best_age_next   = s1_aged;
                        found_zero_next = (s1_aged == '0);
                    end else if (!found_zero_reg && s1_aged < best_age_reg) begin
                        best_pos_next   = s1_pos_reg;
                        best_age_next   = s1_aged;
                        found_zero_next = (s1_aged == '0);
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_frame_next = FRAME_W'(best_pos_reg);
                    m_age_next   = AGE_OUT_W'(best_age_reg);
                    hand_next    = (CW'(best_pos_reg) + CW'(1) >= n_frames) ?
                                   '0 : best_pos_reg + FW'(1);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cfg_reg        <= CFG_RESET;
            ref_reg        <= '0;
            occ_reg        <= '0;
            hand_reg       <= '0;
            issue_cnt_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            found_zero_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            ref_reg        <= ref_next;
            occ_reg        <= occ_next;
            hand_reg       <= hand_next;
            issue_cnt_reg  <= issue_cnt_next;
            s1_valid_reg   <= s1_valid_next;
            found_zero_reg <= found_zero_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_pos_reg <= issue_pos_next;
        s1_first_reg  <= s1_first_next;
        s1_occ_reg    <= s1_occ_next;
        s1_ref_reg    <= s1_ref_next;
        s1_pos_reg    <= s1_pos_next;
        best_pos_reg  <= best_pos_next;
        best_age_reg  <= best_age_next;
        m_frame_reg   <= m_frame_next;
        m_age_reg     <= m_age_next;
    end

    a_s1_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> state_reg == ST_SCAN)
        else $error("read data pending outside scan");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> issue_cnt_reg <= n_frames)
        else $error("scan issued past active frame count");

    a_victim_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH |-> CW'(best_pos_reg) < n_frames)
        else $error("victim outside active frames");

endmodule

`default_nettype wire

// File: tb/sv/aging_victim_select_checker.sv
`timescale 1ns / 100ps
// Checker for aging_victim_select_unit. It tracks ages, marks and the hand from the
// accepted command beats, predicts each victim beat and compares it with the result channel.
// Depends on avs_pkg.
module aging_victim_select_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [avs_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic [avs_pkg::OP_W-1:0]      s_op,
    input  wire logic [avs_pkg::FRAME_W-1:0]   s_frame_index,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic [avs_pkg::FRAME_W-1:0]   m_victim_frame,
    input  wire logic [avs_pkg::AGE_OUT_W-1:0] m_victim_age,
    output int                                 mismatch_count,
    output int                                 victims_pending
);
    import avs_pkg::*;

    localparam int FRAMES = MAX_FRAMES_DEFAULT;
    localparam int AGE_W  = AGE_BITS_DEFAULT;

    typedef struct packed {
        logic [FRAME_W-1:0]   frame;
        logic [AGE_OUT_W-1:0] age;
    } victim_t;

    logic [AGE_W-1:0] frame_age [FRAMES];
    bit               frame_ref [FRAMES];
    bit               frame_used [FRAMES];
    int               scan_hand;
    logic [CFG_W-1:0] active_frames;
    victim_t          expected_victims [$];

    function automatic bit age_and_select(input logic [OP_W-1:0] op,
                                          input logic [FRAME_W-1:0] idx,
                                          output victim_t pick);
        int               n;
        int               start;
        int               best;
        int               pos;
        logic [AGE_W-1:0] best_age;
        pick = '0;
        if (op == OP_REFERENCE || op == OP_INSTALL) begin
            frame_ref[idx] = 1'b1;
            if (op == OP_INSTALL) begin
                frame_used[idx] = 1'b1;
                frame_age[idx]  = '0;
            end
            return 1'b0;
        end
        if (op != OP_VICTIM) return 1'b0;

        if (active_frames == 0) n = 1;
        else if (active_frames > FRAMES) n = FRAMES;
        else n = int'(active_frames);

        for (int i = 0; i < n; i++) begin
            if (frame_used[i]) begin
                frame_age[i] = frame_age[i] >> 1;
                if (frame_ref[i]) begin
                    frame_age[i][AGE_W-1] = 1'b1;
                    frame_ref[i] = 1'b0;
                end
            end
        end

        start    = (scan_hand < n) ? scan_hand : 0;
        best     = start;
        best_age = frame_age[start];
        if (best_age != 0) begin
            for (int i = 1; i < n; i++) begin
                pos = start + i;
                if (pos >= n) pos = pos - n;
                if (frame_age[pos] < best_age) begin
                    best     = pos;
                    best_age = frame_age[pos];
                    if (best_age == 0) break;
                end
            end
        end

        scan_hand  = (best + 1 >= n) ? 0 : best + 1;
        pick.frame = best[FRAME_W-1:0];
        pick.age   = best_age[AGE_OUT_W-1:0];
        return 1'b1;
    endfunction

    always @(posedge aclk) begin : monitor
        victim_t want;
        victim_t pick;
        if (!aresetn) begin
            for (int i = 0; i < FRAMES; i++) begin
                frame_age[i]  = '0;
                frame_ref[i]  = 1'b0;
                frame_used[i] = 1'b0;
            end
            scan_hand     = 0;
            active_frames = CFG_RESET;
            expected_victims.delete();
            mismatch_count  = 0;
            victims_pending <= 0;
        end else begin
            if (cfg_wr_en) active_frames = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (expected_victims.size() == 0) begin
                    $display("%0t: unexpected victim beat, expected none, actual frame %0d age %h",
                             $time, m_victim_frame, m_victim_age);
                    mismatch_count++;
                end else begin
                    want = expected_victims.pop_front();
                    if (m_victim_frame !== want.frame) begin
                        $display("%0t: victim_frame expected %0d actual %0d",
                                 $time, want.frame, m_victim_frame);
                        mismatch_count++;
                    end
                    if (m_victim_age !== want.age) begin
                        $display("%0t: victim_age expected %h actual %h",
                                 $time, want.age, m_victim_age);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (age_and_select(s_op, s_frame_index, pick)) begin
                    expected_victims.insert(expected_victims.size(), pick);
                end
            end
            victims_pending <= expected_victims.size();
        end
    end

endmodule

// File: tb/sv/aging_victim_select_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for aging_victim_select_unit: clock, reset, command and result
// stimulus with random gaps, active frame settings and the final verdict.
// Depends on avs_pkg, aging_victim_select_unit and aging_victim_select_checker.
module aging_victim_select_unit_tb;
    import avs_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int IDLE_LIMIT    = 5000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_BEATS   = 125;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data   = '0;
    logic                 s_valid       = 1'b0;
    logic [OP_W-1:0]      s_op          = '0;
    logic [FRAME_W-1:0]   s_frame_index = '0;
    logic                 m_ready       = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic [FRAME_W-1:0]   m_victim_frame;
    logic [AGE_OUT_W-1:0] m_victim_age;

    int mismatch_count;
    int victims_pending;
    int idle_cycles   = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int frames_live   = 64;
    bit calm          = 1'b0;

    always #4 aclk = ~aclk;

    aging_victim_select_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_frame_index  (s_frame_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_victim_frame (m_victim_frame),
        .m_victim_age   (m_victim_age)
    );

    aging_victim_select_checker victim_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_frame_index   (s_frame_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_victim_frame  (m_victim_frame),
        .m_victim_age    (m_victim_age),
        .mismatch_count  (mismatch_count),
        .victims_pending (victims_pending)
    );

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_beat(input logic [OP_W-1:0] op, input logic [FRAME_W-1:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_frame_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (victims_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_active_frames(input logic [CFG_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (v == 0) frames_live = 1;
        else if (v > MAX_FRAMES_DEFAULT) frames_live = MAX_FRAMES_DEFAULT;
        else frames_live = int'(v);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] cfg, input int beats, input int victim_pct);
        int                 sent;
        int                 r;
        logic [OP_W-1:0]    op;
        logic [FRAME_W-1:0] idx;
        set_active_frames(cfg);
        sent = 0;
        while (sent < beats) begin
            r = $urandom_range(0, 99);
            if (r < victim_pct) op = OP_VICTIM;
            else if (r < victim_pct + 4) op = OP_UNUSED;
            else if (r < victim_pct + 30) op = OP_INSTALL;
            else op = OP_REFERENCE;
            if ($urandom_range(0, 3) != 0) idx = FRAME_W'($urandom_range(0, frames_live - 1));
            else idx = FRAME_W'($urandom_range(0, 63));
            send_beat(op, idx);
            if (op != OP_UNUSED) sent++;
        end
    endtask

    initial begin : receiver
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (holds_served < hold_requests) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int cfg;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // all frames empty, then a few installs and marks at the index extremes
        send_beat(OP_VICTIM, 6'd17);
        send_beat(OP_INSTALL, 6'd0);
        send_beat(OP_INSTALL, 6'd63);
        send_beat(OP_REFERENCE, 6'd5);
        send_beat(OP_UNUSED, 6'd63);
        send_beat(OP_REFERENCE, 6'd63);
        send_beat(OP_VICTIM, 6'd0);
        send_beat(OP_VICTIM, 6'd63);
        send_beat(OP_INSTALL, 6'd62);
        send_beat(OP_VICTIM, 6'd0);

        // single frame, hand left beyond the count, mark beyond the count
        set_active_frames(7'd1);
        send_beat(OP_VICTIM, 6'd0);
        send_beat(OP_REFERENCE, 6'd0);
        send_beat(OP_VICTIM, 6'd0);
        send_beat(OP_REFERENCE, 6'd40);
        send_beat(OP_VICTIM, 6'd0);

        // zero count behaves as one
        set_active_frames(7'd0);
        send_beat(OP_VICTIM, 6'd0);
        send_beat(OP_INSTALL, 6'd0);
        send_beat(OP_VICTIM, 6'd0);

        // count above the frame total is clamped
        set_active_frames(7'd127);
        send_beat(OP_INSTALL, 6'd63);
        send_beat(OP_VICTIM, 6'd0);
        send_beat(OP_VICTIM, 6'd0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            calm = (p == 3);
            case (p)
                0: begin
                    hold_requests++;
                    run_phase(7'd64, PHASE_BEATS, 60);
                end
                1: run_phase(7'd1, PHASE_BEATS, 30);
                2: run_phase(7'd0, PHASE_BEATS, 30);
                3: run_phase(7'd127, PHASE_BEATS, 30);
                default: begin
                    if (p % 2 == 1) cfg = $urandom_range(1, 16);
                    else cfg = $urandom_range(0, 127);
                    run_phase(cfg[CFG_W-1:0], PHASE_BEATS, $urandom_range(15, 45));
                end
            endcase
        end
        calm = 1'b0;

        drain();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
